### rtl/gsc_pkg.sv
`timescale 1ns / 1ps

package gsc_pkg;

  localparam int CODE_W = 21;
  localparam int REFS_W = 16;
  localparam int IDX_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

  // Operation carried in the input tuser
  localparam logic OP_REQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NO_FREE     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RENDER_FAIL = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_REL_ZERO    = 2'd3;

  // Per-slot bookkeeping kept in the cleared memory
  typedef struct packed {
    logic              mapped;
    logic [REFS_W-1:0] refs;
  } slot_meta_t;

  localparam int META_W = $bits(slot_meta_t);

endpackage

### rtl/gsc_ram.sv
`timescale 1ns / 1ps

module gsc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/glyph_slot_cache_top.sv
`timescale 1ns / 1ps

// Reference-counted glyph slot cache. A pool of SLOTS_PER_PAGE * PAGE_COUNT
// slots maps character codes to slots and keeps a 16-bit reference count per
// slot. A require beat (tuser = 0) looks its code up and retains the matching
// slot, or on a miss with render_ok set takes the lowest slot whose count is
// zero; a release beat (tuser = 1) decrements the named slot's nonzero count.
// Every input beat yields exactly one result beat. The state lives in two
// single-port-read memories: one for the mapped codes, one for the mapped
// flag and count. A require walks the pool through the single read port, one
// slot per cycle, and the walk stops at the first match. After reset the
// block clears every slot of the count memory before it accepts a beat. The
// output register lets the next beat be taken while a result waits.
module glyph_slot_cache_top #(
  parameter int SLOTS_PER_PAGE = 64,
  parameter int PAGE_COUNT     = 2
) (
  input  logic        clk,
  input  logic        rst,
  // Input beat
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // char_code[20:0], render_ok[21], release_slot[28:22]
  input  logic        s_tuser,   // op
  // Result beat
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // slot_valid[0], slot_index[7:1], was_hit[8],
                                 // needs_upload[9], status[11:10]
);

  import gsc_pkg::*;

  localparam int TOTAL_SLOTS = SLOTS_PER_PAGE * PAGE_COUNT;
  localparam int AW = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int CW = $clog2(TOTAL_SLOTS + 1);
  localparam int RW = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TOTAL_SLOTS - 1);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_RLS_RD   = 3'd3;
  localparam logic [2:0] ST_RLS_WAIT = 3'd4;
  localparam logic [2:0] ST_FINISH   = 3'd5;

  logic [2:0] state;

  // Request held for the whole operation
  logic              req_op;
  logic [CODE_W-1:0] req_code;
  logic              req_render;
  logic [IDX_W-1:0]  req_rel;

  // Scan bookkeeping
  logic [CW-1:0] scan_cnt;
  logic          pend_valid;
  logic [AW-1:0] pend_addr;
  logic          hit_found;
  logic [AW-1:0] hit_idx;
  logic          free_found;
  logic [AW-1:0] free_idx;
  slot_meta_t    hold_meta;
  logic [AW-1:0] clr_cnt;

  // Memory ports
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [AW-1:0]     ram_waddr;
  logic              code_we;
  logic              meta_we;
  slot_meta_t        meta_wdata;
  logic [CODE_W-1:0] code_rdata;
  slot_meta_t        meta_rdata;
  logic [META_W-1:0] meta_rdata_raw;

  // Finish-step decisions
  logic              fin_code_we;
  logic              fin_meta_we;
  logic [AW-1:0]     fin_addr;
  slot_meta_t        fin_meta;
  logic              fin_valid;
  logic [IDX_W-1:0]  fin_idx;
  logic              fin_hit;
  logic              fin_upload;
  logic [STAT_W-1:0] fin_status;

  logic          out_free;
  logic          fin_go;
  logic          scan_issue;
  logic          rel_in_range;
  logic [RW-1:0] rel_wide;
  logic [AW-1:0] rel_addr;
  logic [RW-1:0] hit_wide;
  logic [RW-1:0] free_wide;

  gsc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TOTAL_SLOTS)
  ) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr (ram_waddr),
    .wdata (req_code),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (code_rdata)
  );

  gsc_ram #(
    .WIDTH (META_W),
    .DEPTH (TOTAL_SLOTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (ram_waddr),
    .wdata (meta_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (meta_rdata_raw)
  );

  assign meta_rdata = slot_meta_t'(meta_rdata_raw);

  assign s_tready     = (state == ST_IDLE);
  assign out_free     = !m_tvalid || m_tready;
  assign fin_go       = (state == ST_FINISH) && out_free;
  assign scan_issue   = (state == ST_SCAN) && (scan_cnt < CW'(TOTAL_SLOTS));
  assign rel_in_range = 32'(req_rel) < 32'(TOTAL_SLOTS);
  assign rel_wide     = RW'(req_rel);
  assign rel_addr     = rel_wide[AW-1:0];
  assign hit_wide     = RW'(hit_idx);
  assign free_wide    = RW'(free_idx);

  // Work out the write-back and the result from what the read phase found.
  always_comb begin
    fin_code_we = 1'b0;
    fin_meta_we = 1'b0;
    fin_addr    = free_idx;
    fin_meta    = '0;
    fin_valid   = 1'b0;
    fin_idx     = '0;
    fin_hit     = 1'b0;
    fin_upload  = 1'b0;
    fin_status  = STATUS_OK;
    if (req_op == OP_RELEASE) begin
      fin_addr = rel_addr;
      fin_idx  = req_rel;
      if (rel_in_range && (hold_meta.refs != '0)) begin
        fin_meta_we     = 1'b1;
        fin_meta.mapped = hold_meta.mapped;
        fin_meta.refs   = hold_meta.refs - REFS_W'(1);
        fin_valid       = 1'b1;
      end else begin
        fin_status = STATUS_REL_ZERO;
      end
    end else if (hit_found) begin
      // Retain the matching slot; the count saturates
      fin_meta_we     = 1'b1;
      fin_addr        = hit_idx;
      fin_meta.mapped = 1'b1;
      fin_meta.refs   = (hold_meta.refs == REFS_MAX) ? REFS_MAX
                                                     : hold_meta.refs + REFS_W'(1);
      fin_valid       = 1'b1;
      fin_idx         = hit_wide[IDX_W-1:0];
      fin_hit         = 1'b1;
    end else if (!free_found) begin
      fin_status = STATUS_NO_FREE;
    end else if (!req_render) begin
      fin_status = STATUS_RENDER_FAIL;
    end else begin
      // Take the lowest free slot: drop its old mapping, map the new code
      fin_code_we     = 1'b1;
      fin_meta_we     = 1'b1;
      fin_addr        = free_idx;
      fin_meta.mapped = 1'b1;
      fin_meta.refs   = REFS_W'(1);
      fin_valid       = 1'b1;
      fin_idx         = free_wide[IDX_W-1:0];
      fin_upload      = 1'b1;
    end
  end

  // Memory port steering
  always_comb begin
    ram_re     = 1'b0;
    ram_raddr  = scan_cnt[AW-1:0];
    ram_waddr  = fin_addr;
    code_we    = 1'b0;
    meta_we    = 1'b0;
    meta_wdata = fin_meta;
    if (state == ST_CLEAR) begin
      ram_waddr  = clr_cnt;
      meta_we    = 1'b1;
      meta_wdata = '0;
    end else if (fin_go) begin
      code_we = fin_code_we;
      meta_we = fin_meta_we;
    end
    if (scan_issue) begin
      ram_re = 1'b1;
    end else if (state == ST_RLS_RD) begin
      ram_re    = 1'b1;
      ram_raddr = rel_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      pend_valid <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tready && !fin_go) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_SLOT) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            req_op     <= s_tuser;
            req_code   <= s_tdata[20:0];
            req_render <= s_tdata[21];
            req_rel    <= s_tdata[28:22];
            scan_cnt   <= '0;
            pend_valid <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= (s_tuser == OP_RELEASE) ? ST_RLS_RD : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one read a cycle, judge the slot whose read was issued the cycle before
          if (scan_issue) begin
            scan_cnt <= scan_cnt + CW'(1);
          end
          pend_valid <= scan_issue;
          pend_addr  <= scan_cnt[AW-1:0];
          if (pend_valid) begin
            if (meta_rdata.mapped && (code_rdata == req_code)) begin
              hit_found <= 1'b1;
              hit_idx   <= pend_addr;
              hold_meta <= meta_rdata;
              state     <= ST_FINISH;
            end else begin
              if (!free_found && (meta_rdata.refs == '0)) begin
                free_found <= 1'b1;
                free_idx   <= pend_addr;
              end
              if (pend_addr == LAST_SLOT) begin
                state <= ST_FINISH;
              end
            end
          end
        end
        ST_RLS_RD: begin
          state <= ST_RLS_WAIT;
        end
        ST_RLS_WAIT: begin
          hold_meta <= meta_rdata;
          state     <= ST_FINISH;
        end
        ST_FINISH: begin
          // Write back and load the result together, once the output is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, fin_status, fin_upload, fin_hit, fin_idx, fin_valid};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A successful result always carries the ok status
  a_valid_means_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[11:10] == STATUS_OK))
    else $error("successful result with error status");

  // A result is either a hit or a new upload, never both
  a_hit_xor_upload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
    else $error("result flagged as both hit and upload");

  // One beat at a time: the block is busy right after taking a beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an operation is in flight");

  // Memories are written only while clearing or when a result is loaded
  a_write_with_result: assert property (@(posedge clk) disable iff (rst)
    (meta_we && (state != ST_CLEAR)) |=> m_tvalid)
    else $error("count memory written without a result");
`endif

endmodule
